### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define RQS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rqs_pkg.sv
// Shared types, codes and sizes of the requantization block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rqs_pkg;

  localparam int LANE_COUNT   = 32;
  localparam int LANE_W       = 5;
  localparam int DATA_W       = 32;
  localparam int SHIFT_IN_W   = 8;
  localparam int SCALE_BYTE_W = 8;
  localparam int SHIFT_W      = 6;
  localparam int SAT_W        = 48;
  localparam int PROD_W       = 64;
  localparam int GSHIFT_W     = 5;
  localparam int SRC_W        = 2;

  localparam int MQ_DEPTH   = 2;
  localparam int MQ_PTR_W   = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W   = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_SCALE = 1'b1
  } req_type_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_GLOBAL = 2'd0,
    SRC_TABLE  = 2'd1,
    SRC_NONE   = 2'd2
  } shift_src_t;

  typedef enum logic [1:0] {
    REG_SCALE_MODE   = 2'd0,
    REG_SHIFT_SOURCE = 2'd1,
    REG_GLOBAL_SHIFT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                scale_mode;
    logic [SRC_W-1:0]    shift_source;
    logic [GSHIFT_W-1:0] global_shift;
  } cfg_t;

  // One scale operation waiting for the multiplier.
  typedef struct packed {
    logic [DATA_W-1:0]  acc;
    logic [DATA_W-1:0]  scale;
    logic [SHIFT_W-1:0] shift;
  } item_t;

endpackage

### hw/rtl/rqs_cfg_regs.sv
// APB register file holding scale mode, shift source and global shift.
// Depends on rqs_pkg.
`timescale 1ns / 1ps

module rqs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rqs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rqs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rqs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output rqs_pkg::cfg_t                     cfg
);

  rqs_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rqs_pkg::REG_SCALE_MODE:   cfg_q.scale_mode   <= pwdata[0];
        rqs_pkg::REG_SHIFT_SOURCE: cfg_q.shift_source <= pwdata[rqs_pkg::SRC_W-1:0];
        rqs_pkg::REG_GLOBAL_SHIFT: cfg_q.global_shift <= pwdata[rqs_pkg::GSHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rqs_pkg::REG_SCALE_MODE:
        prdata = rqs_pkg::APB_DATA_W'(cfg_q.scale_mode);
      rqs_pkg::REG_SHIFT_SOURCE:
        prdata = rqs_pkg::APB_DATA_W'(cfg_q.shift_source);
      rqs_pkg::REG_GLOBAL_SHIFT:
        prdata = rqs_pkg::APB_DATA_W'(cfg_q.global_shift);
      default:
        prdata = '0;
    endcase
  end

endmodule

### hw/rtl/rqs_front.sv
// Front end: accepts items, updates the lane shift table on load items and
// turns scale items into queue entries with the scale and shift resolved.
// Depends on rqs_pkg.
`timescale 1ns / 1ps

module rqs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  rqs_pkg::cfg_t                     cfg,
  input  logic                              push,
  input  logic                              q_full,
  input  logic                              req_type,
  input  logic [rqs_pkg::LANE_W-1:0]        lane,
  input  logic signed [rqs_pkg::SHIFT_IN_W-1:0] shift_in,
  input  logic signed [rqs_pkg::DATA_W-1:0] accumulator,
  input  logic signed [rqs_pkg::DATA_W-1:0] scale_word,
  output logic                              q_push,
  output rqs_pkg::item_t                    q_item
);

  logic [rqs_pkg::SHIFT_IN_W-1:0] lane_shift [rqs_pkg::LANE_COUNT];
  logic                           accept;
  logic                           lane_ok;
  logic [rqs_pkg::SHIFT_IN_W-1:0] tbl_val;
  logic [rqs_pkg::SHIFT_W-1:0]    tbl_shift;
  logic [rqs_pkg::SHIFT_W-1:0]    shift_sel;
  logic [rqs_pkg::DATA_W-1:0]     scale_sel;

  assign accept  = push && !q_full;
  assign lane_ok = (int'(lane) < rqs_pkg::LANE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rqs_pkg::LANE_COUNT; i++) begin
        lane_shift[i] <= '0;
      end
    end else if (accept && (req_type == rqs_pkg::REQ_LOAD) && lane_ok) begin
      lane_shift[lane] <= shift_in;
    end
  end

  // Lanes outside the table read as a zero shift.
  assign tbl_val = lane_ok ? lane_shift[lane] : '0;

  // Negative entries clamp to zero, entries of 64 and above clamp to 63.
  always_comb begin
    if (tbl_val[rqs_pkg::SHIFT_IN_W-1]) begin
      tbl_shift = '0;
    end else if (|tbl_val[rqs_pkg::SHIFT_IN_W-2:rqs_pkg::SHIFT_W]) begin
      tbl_shift = '1;
    end else begin
      tbl_shift = tbl_val[rqs_pkg::SHIFT_W-1:0];
    end
  end

  always_comb begin
    case (cfg.shift_source)
      rqs_pkg::SRC_GLOBAL: shift_sel = rqs_pkg::SHIFT_W'(cfg.global_shift);
      rqs_pkg::SRC_TABLE:  shift_sel = tbl_shift;
      default:             shift_sel = '0;
    endcase
  end

  assign scale_sel = cfg.scale_mode ? scale_word :
    {{(rqs_pkg::DATA_W - rqs_pkg::SCALE_BYTE_W){scale_word[rqs_pkg::SCALE_BYTE_W-1]}},
     scale_word[rqs_pkg::SCALE_BYTE_W-1:0]};

  assign q_push       = accept && (req_type == rqs_pkg::REQ_SCALE);
  assign q_item.acc   = accumulator;
  assign q_item.scale = scale_sel;
  assign q_item.shift = shift_sel;

endmodule

### hw/rtl/rqs_queue.sv
// Short queue that decouples the front end from the multiply pipeline.
// Depends on rqs_pkg.
`timescale 1ns / 1ps

module rqs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rqs_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output rqs_pkg::item_t rd_item,
  output logic           empty
);

  rqs_pkg::item_t                mem [rqs_pkg::MQ_DEPTH];
  logic [rqs_pkg::MQ_PTR_W-1:0]  wr_ptr;
  logic [rqs_pkg::MQ_PTR_W-1:0]  rd_ptr;
  logic [rqs_pkg::MQ_CNT_W-1:0]  count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count == rqs_pkg::MQ_CNT_W'(rqs_pkg::MQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rqs_pkg::MQ_PTR_W'(rqs_pkg::MQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rqs_pkg::MQ_PTR_W'(rqs_pkg::MQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/rqs_back.sv
// Back end: multiply, saturate to 48 bits, arithmetic right shift, and the
// result queue. Depends on rqs_pkg.
`timescale 1ns / 1ps

module rqs_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  rqs_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [rqs_pkg::DATA_W-1:0] result
);

  localparam int SAT_MAG_W = rqs_pkg::SAT_W - 1;

  // Credit count: items in the two pipeline stages plus the result queue.
  logic [rqs_pkg::OQ_CNT_W-1:0] credit;
  logic                         out_pop;

  logic signed [rqs_pkg::DATA_W-1:0] acc_s;
  logic signed [rqs_pkg::DATA_W-1:0] scale_s;
  logic signed [rqs_pkg::PROD_W-1:0] prod_c;

  logic                              s1_valid;
  logic signed [rqs_pkg::PROD_W-1:0] s1_prod;
  logic [rqs_pkg::SHIFT_W-1:0]       s1_shift;

  logic                              ovf_hi;
  logic                              ovf_lo;
  logic signed [rqs_pkg::SAT_W-1:0]  sat_c;
  logic signed [rqs_pkg::SAT_W-1:0]  shifted_c;

  logic                              s2_valid;
  logic [rqs_pkg::DATA_W-1:0]        s2_result;

  logic [rqs_pkg::DATA_W-1:0]   oq [rqs_pkg::OQ_DEPTH];
  logic [rqs_pkg::OQ_PTR_W-1:0] oq_wr_ptr;
  logic [rqs_pkg::OQ_PTR_W-1:0] oq_rd_ptr;
  logic [rqs_pkg::OQ_CNT_W-1:0] oq_count;

  assign out_pop = pop && !empty;
  assign q_pop   = !q_empty && (credit < rqs_pkg::OQ_CNT_W'(rqs_pkg::OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (q_pop && !out_pop) begin
      credit <= credit + 1'b1;
    end else if (out_pop && !q_pop) begin
      credit <= credit - 1'b1;
    end
  end

  // Stage 1: full 32 x 32 signed product.
  assign acc_s   = q_item.acc;
  assign scale_s = q_item.scale;
  assign prod_c  = rqs_pkg::PROD_W'(acc_s) * rqs_pkg::PROD_W'(scale_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod  <= prod_c;
      s1_shift <= q_item.shift;
    end
  end

  // Stage 2: the product fits in 48 bits when bits 63..47 all agree.
  assign ovf_hi = !s1_prod[rqs_pkg::PROD_W-1] && (|s1_prod[rqs_pkg::PROD_W-2:SAT_MAG_W]);
  assign ovf_lo = s1_prod[rqs_pkg::PROD_W-1] && !(&s1_prod[rqs_pkg::PROD_W-2:SAT_MAG_W]);

  always_comb begin
    if (ovf_hi) begin
      sat_c = {1'b0, {SAT_MAG_W{1'b1}}};
    end else if (ovf_lo) begin
      sat_c = {1'b1, {SAT_MAG_W{1'b0}}};
    end else begin
      sat_c = s1_prod[rqs_pkg::SAT_W-1:0];
    end
  end

  assign shifted_c = sat_c >>> s1_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_result <= shifted_c[rqs_pkg::DATA_W-1:0];
    end
  end

  // Result queue; the credit count keeps it from overflowing.
  assign empty  = (oq_count == '0);
  assign result = oq[oq_rd_ptr];

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      oq[oq_wr_ptr] <= s2_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr_ptr <= '0;
      oq_rd_ptr <= '0;
      oq_count  <= '0;
    end else begin
      if (s2_valid) begin
        oq_wr_ptr <= (oq_wr_ptr == rqs_pkg::OQ_PTR_W'(rqs_pkg::OQ_DEPTH - 1)) ?
                     '0 : oq_wr_ptr + 1'b1;
      end
      if (out_pop) begin
        oq_rd_ptr <= (oq_rd_ptr == rqs_pkg::OQ_PTR_W'(rqs_pkg::OQ_DEPTH - 1)) ?
                     '0 : oq_rd_ptr + 1'b1;
      end
      if (s2_valid && !out_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (out_pop && !s2_valid) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/requant_scale_saturate_shift.sv
// Top level of the accumulator requantization block.
// Depends on rqs_pkg, rqs_cfg_regs, rqs_front, rqs_queue and rqs_back.
//
// Usage:
//   Configuration goes through the APB port (scale_mode at 0x0,
//   shift_source at 0x4, global_shift at 0x8) while the block is idle.
//   Items enter through push/full: an item transfers on a clock edge with
//   push high and full low. A load item (req_type 0) writes the lane's
//   shift byte into the table at once and yields no result. A scale item
//   (req_type 1) yields one 32-bit result.
//   Results leave through empty/pop: the oldest result sits on the result
//   port while empty is low and transfers on an edge with pop high.
//   A scale item accepted into the item queue reaches the result port through
//   the multiply register, the saturate/shift register and the result
//   queue. Throughput: one item per cycle while results are popped as they
//   arrive, since every stage, the single 32 x 32 multiply included,
//   advances each cycle and the credit count never throttles such a stream.
//   When pop is held low the four-entry result queue fills, the multiply
//   pipeline stops drawing items, the two-entry item queue fills and full
//   rises; no item is lost.
//   Reset (synchronous, active high) clears the configuration registers, the
//   shift table and all queues; full and empty are low and high right after it.
`timescale 1ns / 1ps

module requant_scale_saturate_shift (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rqs_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [rqs_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [rqs_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  req_type,
  input  logic [rqs_pkg::LANE_W-1:0]            lane,
  input  logic signed [rqs_pkg::SHIFT_IN_W-1:0] shift_in,
  input  logic signed [rqs_pkg::DATA_W-1:0]     accumulator,
  input  logic signed [rqs_pkg::DATA_W-1:0]     scale_word,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [rqs_pkg::DATA_W-1:0]     result
);

  rqs_pkg::cfg_t  cfg;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  rqs_pkg::item_t wr_item;
  rqs_pkg::item_t rd_item;

  assign full = q_full;

  rqs_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rqs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .q_full      (q_full),
    .req_type    (req_type),
    .lane        (lane),
    .shift_in    (shift_in),
    .accumulator (accumulator),
    .scale_word  (scale_word),
    .q_push      (q_push),
    .q_item      (wr_item)
  );

  rqs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  rqs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_item  (rd_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

### hw/rtl/rqs_checker.sv
// Port-level checker for the requantization block, bound to the top level.
// Depends on rqs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rqs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              push,
  input logic                              full,
  input logic                              pop,
  input logic                              empty,
  input logic signed [rqs_pkg::DATA_W-1:0] result
);

  logic in_xfer;

  assign in_xfer = push && !full;

  // Reset leaves no result waiting and the input open.
  `RQS_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (empty && !full), "reset did not clear queues")

  // No result can appear without an item transfer that could have reached the result queue by now.
  `RQS_ASSERT(a_no_spurious_result, clk, rst, (empty && !in_xfer && !$past(in_xfer) && !$past(in_xfer, 2) && !$past(in_xfer, 3)) |=> empty, "result appeared without input")

  // The input side fills up only through transfers.
  `RQS_ASSERT(a_full_needs_push, clk, rst, (!full && !in_xfer) |=> !full, "full rose without a transfer")

  // A waiting result stays put until it is taken.
  `RQS_ASSERT(a_result_holds, clk, rst, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")

endmodule

bind requant_scale_saturate_shift rqs_checker u_rqs_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);
